### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo widener
// Clocked checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define HSW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// check that a condition implies another one on the next edge
`define HSW_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");

`endif

### src/hsw_pkg.sv
// ----------------------------------------------------------------------------
// hsw_pkg
// Types, constants and register codes shared by the stereo widener.
// ----------------------------------------------------------------------------
package hsw_pkg;

    localparam int LINE_DEPTH_DEF  = 2048;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int COEF_W  = 18;
    localparam int DELAY_W = 11;
    localparam int PACK_W  = 54;
    localparam int IDX_W   = 3;

    localparam logic [DELAY_W-1:0] DELAY_RST = 11'd480;
    localparam logic [COEF_W-1:0]  DRY_RST   = 18'd65536;
    localparam logic [COEF_W-1:0]  WET_RST   = 18'd32845;
    localparam logic [COEF_W-1:0]  OUT_RST   = 18'd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_DELAY  = 3'd0,
        REG_DRY    = 3'd1,
        REG_WET    = 3'd2,
        REG_OUT    = 3'd3,
        REG_HP     = 3'd4,
        REG_LP     = 3'd5,
        REG_BYPASS = 3'd6
    } t_reg;

    typedef enum logic [3:0] {
        OP_HB0 = 4'd0,
        OP_HA1 = 4'd1,
        OP_HA2 = 4'd2,
        OP_LB0 = 4'd3,
        OP_LA1 = 4'd4,
        OP_LA2 = 4'd5,
        OP_DL  = 4'd6,
        OP_WF  = 4'd7,
        OP_DR  = 4'd8,
        OP_OL  = 4'd9,
        OP_OR  = 4'd10
    } t_op;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WR   = 7'b0000010,
        S_RD   = 7'b0000100,
        S_LOAD = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_POST = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic start;
        logic sgn;
    } t_mul_req;

endpackage

### src/hsw_mul.sv
// ----------------------------------------------------------------------------
// hsw_mul
// Bit-serial multiplier: one multiplier bit per cycle, shift-add.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsw_mul #(
    parameter int MW = hsw_pkg::SAMPLE_BITS_DEF + 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hsw_pkg::t_mul_req             i_req,
    input  logic signed [MW-1:0]          i_mcand,
    input  logic [hsw_pkg::COEF_W-1:0]    i_mplier,
    output logic                          o_done,
    output logic signed [MW+hsw_pkg::COEF_W:0] o_prod
);
    import hsw_pkg::*;

    localparam int CNT_W = $clog2(COEF_W + 1);

    logic                r_busy;
    logic                r_done;
    logic                r_sgn;
    logic [CNT_W-1:0]    r_cnt;
    logic signed [MW-1:0] r_mcand;
    logic signed [MW:0]   r_hi;
    logic [COEF_W-1:0]    r_lo;

    logic                  c_last;
    logic signed [MW+1:0]  c_add;
    logic signed [MW+1:0]  c_sum;

    always_comb begin
        c_last = (r_cnt == CNT_W'(COEF_W - 1));
        c_add  = r_lo[0] ? {{2{r_mcand[MW-1]}}, r_mcand} : '0;
        if (c_last && r_sgn) begin
            c_sum = {r_hi[MW], r_hi} - c_add;
        end else begin
            c_sum = {r_hi[MW], r_hi} + c_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (c_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_mcand;
            r_sgn   <= i_req.sgn;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= c_sum[MW+1:1];
            r_lo <= {c_sum[0], r_lo[COEF_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

    `HSW_ASSERT(a_cnt_range, !r_busy || (r_cnt < CNT_W'(COEF_W)))
    `HSW_ASSERT_NEXT(a_done_once, r_done, !r_done)

endmodule

### src/hsw_delay.sv
// ----------------------------------------------------------------------------
// hsw_delay
// Ring delay line of left+right sums with fill count and registered read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsw_delay #(
    parameter int LINE_DEPTH  = hsw_pkg::LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = hsw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [hsw_pkg::DELAY_W-1:0]   i_delay,
    input  logic signed [SAMPLE_BITS:0]   i_sum,
    output logic signed [SAMPLE_BITS-1:0] o_x
);
    import hsw_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);

    logic signed [SAMPLE_BITS:0] mem [LINE_DEPTH];

    logic [AW-1:0]  r_wi;
    logic [AW:0]    r_fill;
    logic           r_vld;
    logic           r_d0;
    logic signed [SAMPLE_BITS:0] r_wsum;
    logic signed [SAMPLE_BITS:0] r_q;

    logic [AW-1:0]  c_d;
    logic [AW:0]    c_wrap;
    logic [AW-1:0]  c_rd;
    logic           c_vld;
    logic signed [SAMPLE_BITS:0] c_sel;

    always_comb begin
        if (int'(i_delay) > LINE_DEPTH - 1) begin
            c_d = AW'(LINE_DEPTH - 1);
        end else begin
            c_d = AW'(i_delay);
        end
        c_wrap = {1'b0, r_wi} + (AW+1)'(LINE_DEPTH) - {1'b0, c_d};
        if (r_wi >= c_d) begin
            c_rd = r_wi - c_d;
        end else begin
            c_rd = c_wrap[AW-1:0];
        end
        // entries at or above the fill count were never written: read zero
        c_vld = (r_fill == (AW+1)'(LINE_DEPTH)) || ({1'b0, c_rd} < r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi   <= '0;
            r_fill <= '0;
        end else if (i_go) begin
            r_wi <= (r_wi == AW'(LINE_DEPTH - 1)) ? '0 : r_wi + AW'(1);
            if (r_fill != (AW+1)'(LINE_DEPTH)) begin
                r_fill <= r_fill + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            mem[r_wi] <= i_sum;
            r_q       <= mem[c_rd];
            r_wsum    <= i_sum;
            r_vld     <= c_vld;
            r_d0      <= (c_d == '0);
        end
    end

    always_comb begin
        if (r_d0) begin
            c_sel = r_wsum;
        end else if (r_vld) begin
            c_sel = r_q;
        end else begin
            c_sel = '0;
        end
    end

    // floor of half the sum
    assign o_x = c_sel[SAMPLE_BITS:1];

    `HSW_ASSERT(a_fill_max, r_fill <= (AW+1)'(LINE_DEPTH))
    `HSW_ASSERT(a_wi_follows_fill,
                (r_fill == (AW+1)'(LINE_DEPTH)) || ({1'b0, r_wi} == r_fill))

endmodule

### src/haas_stereo_widener_core.sv
// ----------------------------------------------------------------------------
// haas_stereo_widener_core
// Haas stereo widener: delayed mono sum through two biquads, mixed into L/R.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stereo pair per item, m_axis returns one pair per item.
//   Registers are written on the cfg channel (index, data); o_cfg_ready is
//   always high. Write them only while no item is in flight.
//   One item is worked on at a time. Each item is written to the delay
//   line and read back from it, then goes through eleven products, each
//   made by the shared bit-serial multiplier at one multiplier bit per
//   cycle with a load step, the multiply up to its done strobe and a post
//   step, and last through the output load.
//   With bypass set an item goes from accept straight to the output load,
//   untouched, and the next pair is accepted once that load is done.
//   Reset clears the filter states, the write index and the fill count of the
//   delay line (unwritten entries read as zero, no clearing pass) and loads
//   the register defaults.
//   A finished item sits in the output register until m_axis_tready; the
//   next item is accepted meanwhile and stops at the output until that
//   register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module haas_stereo_widener_core #(
    parameter int LINE_DEPTH  = hsw_pkg::LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = hsw_pkg::SAMPLE_BITS_DEF,
    parameter int TD_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [TD_W-1:0]             s_axis_tdata,   // left_in, right_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [TD_W-1:0]             m_axis_tdata,   // left_out, right_out
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hsw_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [hsw_pkg::PACK_W-1:0]  i_cfg_data
);
    import hsw_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int MW = SB + 4;
    localparam int PW = MW + COEF_W + 1;
    localparam logic signed [63:0] SMAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
    localparam logic signed [63:0] S32MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32MIN = -64'sd2147483648;

    function automatic logic signed [63:0] rnd16(input logic signed [63:0] a);
        return (a + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] a,
                                               input logic signed [63:0] hi,
                                               input logic signed [63:0] lo);
        logic signed [63:0] v;
        v = a;
        if (a > hi) v = hi;
        if (a < lo) v = lo;
        return v;
    endfunction

    // configuration
    logic [DELAY_W-1:0] r_delay;
    logic [COEF_W-1:0]  r_dry, r_wet, r_outg;
    logic [PACK_W-1:0]  r_hp, r_lp;
    logic               r_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RST;
            r_dry    <= DRY_RST;
            r_wet    <= WET_RST;
            r_outg   <= OUT_RST;
            r_hp     <= '0;
            r_lp     <= '0;
            r_bypass <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_DELAY:  r_delay  <= i_cfg_data[DELAY_W-1:0];
                REG_DRY:    r_dry    <= i_cfg_data[COEF_W-1:0];
                REG_WET:    r_wet    <= i_cfg_data[COEF_W-1:0];
                REG_OUT:    r_outg   <= i_cfg_data[COEF_W-1:0];
                REG_HP:     r_hp     <= i_cfg_data;
                REG_LP:     r_lp     <= i_cfg_data;
                REG_BYPASS: r_bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // control and datapath registers
    t_state r_state;
    t_op    r_op;
    logic signed [SB-1:0] r_l, r_r, r_x, r_y;
    logic signed [SB-1:0] r_res_l, r_res_r;
    logic signed [PW-1:0] r_bx, r_acc, r_wf;
    logic signed [MW-1:0] r_ml, r_mr;
    logic signed [31:0]   r_hs1, r_hs2, r_ls1, r_ls2;
    logic                 r_out_vld;
    logic signed [SB-1:0] r_out_l, r_out_r;

    logic                 c_accept;
    logic                 c_lp;
    logic [PACK_W-1:0]    c_coefs;
    t_mul_req             c_req;
    logic signed [MW-1:0] c_mcand;
    logic [COEF_W-1:0]    c_mplier;
    logic                 mul_done;
    logic signed [PW-1:0] mul_prod;
    logic signed [SB-1:0] dly_x;
    logic signed [SB:0]   c_sum;

    logic signed [63:0] p64, bx64, s1e, s2e, c_y, c_n1, c_n2, c_ml, c_mr, c_o, c_b1x;

    assign s_axis_tready = (r_state == S_IDLE);
    assign c_accept      = s_axis_tvalid && s_axis_tready;
    assign c_lp          = (r_op == OP_LB0) || (r_op == OP_LA1) || (r_op == OP_LA2);
    assign c_coefs       = c_lp ? r_lp : r_hp;
    assign c_sum         = {r_l[SB-1], r_l} + {r_r[SB-1], r_r};

    always_comb begin
        c_req.start = (r_state == S_LOAD);
        c_req.sgn   = 1'b1;
        c_mcand     = {{4{r_x[SB-1]}}, r_x};
        c_mplier    = c_coefs[53:36];
        case (r_op)
            OP_HB0, OP_LB0: begin
                c_mplier = c_coefs[53:36];
            end
            OP_HA1, OP_LA1: begin
                c_mcand  = {{4{r_y[SB-1]}}, r_y};
                c_mplier = c_coefs[35:18];
            end
            OP_HA2, OP_LA2: begin
                c_mcand  = {{4{r_y[SB-1]}}, r_y};
                c_mplier = c_coefs[17:0];
            end
            OP_DL: begin
                c_mcand   = {{4{r_l[SB-1]}}, r_l};
                c_mplier  = r_dry;
                c_req.sgn = 1'b0;
            end
            OP_WF: begin
                c_mcand   = {{4{r_y[SB-1]}}, r_y};
                c_mplier  = r_wet;
                c_req.sgn = 1'b0;
            end
            OP_DR: begin
                c_mcand   = {{4{r_r[SB-1]}}, r_r};
                c_mplier  = r_dry;
                c_req.sgn = 1'b0;
            end
            OP_OL: begin
                c_mcand   = r_ml;
                c_mplier  = r_outg;
                c_req.sgn = 1'b0;
            end
            OP_OR: begin
                c_mcand   = r_mr;
                c_mplier  = r_outg;
                c_req.sgn = 1'b0;
            end
            default: ;
        endcase
    end

    hsw_mul #(.MW(MW)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (c_req),
        .i_mcand  (c_mcand),
        .i_mplier (c_mplier),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    hsw_delay #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SB)) u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_state == S_WR),
        .i_delay (r_delay),
        .i_sum   (c_sum),
        .o_x     (dly_x)
    );

    // post-multiply arithmetic
    always_comb begin
        p64   = {{(64-PW){mul_prod[PW-1]}}, mul_prod};
        bx64  = {{(64-PW){r_bx[PW-1]}}, r_bx};
        s1e   = c_lp ? 64'(r_ls1) : 64'(r_hs1);
        s2e   = c_lp ? 64'(r_ls2) : 64'(r_hs2);
        // high-pass has b1 = -2*b0, low-pass b1 = 2*b0
        c_b1x = c_lp ? (bx64 <<< 1) : -(bx64 <<< 1);
        c_y   = sat(rnd16(p64 + (s1e <<< 16)), SMAX, SMIN);
        c_n1  = sat(rnd16(c_b1x - p64) + s2e, S32MAX, S32MIN);
        c_n2  = sat(rnd16(bx64 - p64), S32MAX, S32MIN);
        c_ml  = rnd16({{(64-PW){r_acc[PW-1]}}, r_acc} + p64);
        c_mr  = rnd16(p64 - {{(64-PW){r_wf[PW-1]}}, r_wf});
        c_o   = sat(rnd16(p64), SMAX, SMIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_HB0;
            r_out_vld <= 1'b0;
            r_hs1     <= '0;
            r_hs2     <= '0;
            r_ls1     <= '0;
            r_ls2     <= '0;
        end else begin
            // drop the output item once taken, unless a new one loads now
            if (m_axis_tready && r_state != S_OUT) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (c_accept) begin
                        r_op    <= OP_HB0;
                        r_state <= r_bypass ? S_OUT : S_WR;
                    end
                end
                S_WR: r_state <= S_RD;
                S_RD: r_state <= S_LOAD;
                S_LOAD: r_state <= S_MUL;
                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    case (r_op)
                        OP_HA1: r_hs1 <= 32'(c_n1);
                        OP_HA2: r_hs2 <= 32'(c_n2);
                        OP_LA1: r_ls1 <= 32'(c_n1);
                        OP_LA2: r_ls2 <= 32'(c_n2);
                        default: ;
                    endcase
                    if (r_op == OP_OR) begin
                        r_state <= S_OUT;
                    end else begin
                        r_op    <= t_op'(r_op + 4'd1);
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_l     <= s_axis_tdata[SB-1:0];
            r_r     <= s_axis_tdata[2*SB-1:SB];
            r_res_l <= s_axis_tdata[SB-1:0];
            r_res_r <= s_axis_tdata[2*SB-1:SB];
        end
        if (r_state == S_RD) begin
            r_x <= dly_x;
        end
        if (r_state == S_POST) begin
            case (r_op)
                OP_HB0, OP_LB0: begin
                    r_bx <= mul_prod;
                    r_y  <= SB'(c_y);
                end
                OP_HA2:  r_x     <= r_y;
                OP_DL:   r_acc   <= mul_prod;
                OP_WF: begin
                    r_wf <= mul_prod;
                    r_ml <= MW'(c_ml);
                end
                OP_DR:   r_mr    <= MW'(c_mr);
                OP_OL:   r_res_l <= SB'(c_o);
                OP_OR:   r_res_r <= SB'(c_o);
                default: ;
            endcase
        end
        if (r_state == S_OUT && (!r_out_vld || m_axis_tready)) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TD_W'({r_out_r, r_out_l});

    `HSW_ASSERT(a_done_in_mul, !mul_done || (r_state == S_MUL))
    `HSW_ASSERT_NEXT(a_load_starts_mul, r_state == S_LOAD, r_state == S_MUL)

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo widener core testbench
// Drives stereo pairs and register writes into the core. A scoreboard keeps
// its own delay line, filter states and gains, predicts each output pair and
// compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module tb;
    import hsw_pkg::*;

    localparam int SB    = 24;
    localparam int DEPTH = 2048;
    localparam int WDOG  = 20000;

    typedef struct packed {
        logic signed [SB-1:0] right;
        logic signed [SB-1:0] left;
    } t_pair;

    class widener_scoreboard;
        logic [DELAY_W-1:0] delay;
        logic [COEF_W-1:0]  dry, wet, gain;
        logic [PACK_W-1:0]  hp, lp;
        logic               byp;
        longint             sum_line[DEPTH];
        int                 wr_ptr;
        longint             hs1, hs2, ls1, ls2;
        t_pair              pending[$];
        int                 errors;

        function new();
            delay = DELAY_RST;
            dry = DRY_RST;
            wet = WET_RST;
            gain = OUT_RST;
            hp = '0;
            lp = '0;
            byp = 1'b0;
            foreach (sum_line[i]) sum_line[i] = 0;
            wr_ptr = 0;
            hs1 = 0; hs2 = 0; ls1 = 0; ls2 = 0;
            errors = 0;
        endfunction

        function void set_reg(t_reg idx, logic [PACK_W-1:0] val);
            case (idx)
                REG_DELAY:  delay = val[DELAY_W-1:0];
                REG_DRY:    dry = val[COEF_W-1:0];
                REG_WET:    wet = val[COEF_W-1:0];
                REG_OUT:    gain = val[COEF_W-1:0];
                REG_HP:     hp = val;
                REG_LP:     lp = val;
                REG_BYPASS: byp = val[0];
                default: ;
            endcase
        endfunction

        function longint rnd16(longint a);
            return (a + 32768) >>> 16;
        endfunction

        function longint clip(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint biquad(longint x, logic [PACK_W-1:0] c, bit high,
                                inout longint s1, inout longint s2);
            longint b0, a1, a2, b1, y;
            b0 = longint'($signed(c[53:36]));
            a1 = longint'($signed(c[35:18]));
            a2 = longint'($signed(c[17:0]));
            b1 = high ? -2 * b0 : 2 * b0;
            y  = clip(rnd16(b0 * x + s1 * 65536), SB);
            s1 = clip(rnd16(b1 * x - a1 * y) + s2, 32);
            s2 = clip(rnd16(b0 * x - a2 * y), 32);
            return y;
        endfunction

        function void note_input(t_pair p);
            longint l, r, x, f, ml, mr;
            int rd;
            t_pair e;
            if (byp) begin
                pending = {pending, p};
                return;
            end
            l = longint'(p.left);
            r = longint'(p.right);
            sum_line[wr_ptr] = l + r;
            rd = (wr_ptr - int'(delay) + DEPTH) % DEPTH;
            x = sum_line[rd] >>> 1;
            f = biquad(x, hp, 1'b1, hs1, hs2);
            f = biquad(f, lp, 1'b0, ls1, ls2);
            ml = rnd16(longint'(dry) * l + longint'(wet) * f);
            mr = rnd16(longint'(dry) * r - longint'(wet) * f);
            e.left  = SB'(clip(rnd16(ml * longint'(gain)), SB));
            e.right = SB'(clip(rnd16(mr * longint'(gain)), SB));
            wr_ptr = (wr_ptr + 1) % DEPTH;
            pending = {pending, e};
        endfunction

        function void check_output(t_pair got);
            t_pair e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected output pair %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.left !== e.left) begin
                $display("%0t: left_out expected %0d actual %0d", $time, e.left, got.left);
                errors++;
            end
            if (got.right !== e.right) begin
                $display("%0t: right_out expected %0d actual %0d",
                         $time, e.right, got.right);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk, i_rst_n;
    logic                s_axis_tvalid, s_axis_tready;
    logic [2*SB-1:0]     s_axis_tdata;
    logic                m_axis_tvalid, m_axis_tready;
    logic [2*SB-1:0]     m_axis_tdata;
    logic                i_cfg_valid, o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index;
    logic [PACK_W-1:0]   i_cfg_data;

    widener_scoreboard sb;
    int src_idle, snk_idle, quiet;

    haas_stereo_widener_core DUT (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random backpressure on the output side
    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(t_reg'(i_cfg_index), i_cfg_data);
            if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (i_cfg_valid && o_cfg_ready)
                || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet > WDOG) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {r, l};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold until every pair is back, then let the core settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [PACK_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [PACK_W-1:0] coef_set(int b0, int a1, int a2);
        logic [17:0] c0, c1, c2;
        c0 = 18'(b0); c1 = 18'(a1); c2 = 18'(a2);
        return {c0, c1, c2};
    endfunction

    function automatic logic [PACK_W-1:0] rand_coefs();
        if ($urandom_range(3) == 0) return PACK_W'({$urandom, $urandom});
        return coef_set($urandom_range(10000, 45000), -$urandom_range(60000, 125000),
                        $urandom_range(10000, 60000));
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return SB'($urandom_range(255) - 128);
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        write_reg(REG_DELAY,
                  PACK_W'($urandom_range(1) ? $urandom_range(15) : $urandom_range(2047)));
        write_reg(REG_DRY, PACK_W'($urandom_range(4) == 0 ? 0 : $urandom_range(262143)));
        write_reg(REG_WET, PACK_W'($urandom_range(262143)));
        write_reg(REG_OUT, PACK_W'($urandom_range(1) ? 65536 : $urandom_range(262143)));
        write_reg(REG_HP, rand_coefs());
        write_reg(REG_LP, rand_coefs());
        write_reg(REG_BYPASS, PACK_W'($urandom_range(9) == 0));
        if ($urandom_range(7) == 0) write_reg(t_reg'(3'd7), PACK_W'({$urandom, $urandom}));
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        src_idle = 6;
        snk_idle = 47;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults, sample extremes
        send_pair(24'sh7FFFFF, 24'sh7FFFFF);
        send_pair(24'sh800000, 24'sh800000);
        send_pair(24'sh7FFFFF, 24'sh800000);
        send_pair(24'sd0, 24'sd0);
        send_pair(-24'sd1, 24'sd1);
        drain();
        // zero delay, maximum gains, dry off, live filters
        write_reg(REG_DELAY, 0);
        write_reg(REG_DRY, 0);
        write_reg(REG_WET, 18'h3FFFF);
        write_reg(REG_OUT, 18'h3FFFF);
        write_reg(REG_HP, coef_set(30000, -110000, 50000));
        write_reg(REG_LP, coef_set(20000, -90000, 30000));
        repeat (4) send_pair(24'sh7FFFFF, 24'sh7FFFFF);
        send_pair(24'sh800000, 24'sh800000);
        drain();
        // longest delay, extreme coefficients
        write_reg(REG_DELAY, 11'h7FF);
        write_reg(REG_DRY, 18'h3FFFF);
        write_reg(REG_HP, {18'h1FFFF, 18'h20000, 18'h20000});
        write_reg(REG_LP, {18'h20000, 18'h1FFFF, 18'h1FFFF});
        write_reg(REG_OUT, 0);
        send_pair(24'sh400000, 24'sh400000);
        drain();
        write_reg(REG_OUT, 65536);
        send_pair(24'sh7FFFFF, 24'sh800000);
        send_pair(24'sh123456, 24'sh654321);
        drain();
        // bypass, then an unknown register index that must change nothing
        write_reg(REG_BYPASS, 1);
        send_pair(24'sh800000, 24'sh7FFFFF);
        send_pair(24'sh0F0F0F, 24'shF0F0F0);
        drain();
        write_reg(REG_BYPASS, 0);
        write_reg(t_reg'(3'd7), '1);
        send_pair(24'sh7FFFFF, 24'sh000001);
        send_pair(24'sh800000, 24'shFFFFFF);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = ph == 0 ? 6 : (ph == 1 ? 47 : 0);
            snk_idle = ph == 0 ? 47 : (ph == 1 ? 6 : 0);
            for (int blk = 0; blk < 15; blk++) begin
                random_setup();
                repeat (41) send_pair(rand_sample(), rand_sample());
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
